// File: hdl/xrcd_pkg.sv
`timescale 1ns / 1ps
package xrcd_pkg;

  localparam int COORD_W   = 12;
  localparam int RUN_LEN_W = 6;
  localparam int MAX_RUN   = 64;
  localparam int CFG_IDX_W = 2;

  localparam int JOB_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  localparam logic [COORD_W-1:0] WIDTH_RESET  = 12'd80;
  localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'd150;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [7:0] BOLD_LOW  = 8'h20;
  localparam logic [7:0] BOLD_HIGH = 8'h7a;
  localparam logic [3:0] BG_FOLD   = 4'd8;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_REP_CHAR = 2'd1,
    MODE_REP_ATTR = 2'd2,
    MODE_REP_BOTH = 2'd3
  } run_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         cell_char;
    logic [3:0]         fg_index;
    logic [3:0]         bg_index;
    logic               bold;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic               in_bounds;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic                 restart;
    logic [7:0]           cell_char;
    logic [7:0]           attr;
    logic [RUN_LEN_W-1:0] len_m1;
  } job_t;

  typedef struct packed {
    logic               busy;
    logic               cell_fire;
    logic               restart_pop;
    logic [COORD_W-1:0] row;
  } back_status_t;

endpackage

// File: hdl/xrcd_fifo.sv
`timescale 1ns / 1ps
module xrcd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push_ok, pop_ok;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hdl/xrcd_front.sv
`timescale 1ns / 1ps
module xrcd_front #(
  parameter int JOB_DEPTH = xrcd_pkg::JOB_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  xrcd_pkg::in_item_t            in_item,
  input  logic [xrcd_pkg::COORD_W-1:0]  image_height,
  output logic                          q_push,
  output xrcd_pkg::job_t                q_data,
  input  logic                          q_full,
  input  logic                          q_empty,
  input  xrcd_pkg::back_status_t        bk
);

  localparam int PEND_MAX = (JOB_DEPTH + 1) * xrcd_pkg::MAX_RUN;
  localparam int PEND_W   = $clog2(PEND_MAX + 1);
  localparam int SUM_W    = xrcd_pkg::COORD_W + PEND_W;
  localparam int REM_W    = xrcd_pkg::RUN_LEN_W + 1;

  typedef enum logic [1:0] {
    PH_RUN,
    PH_CHAR,
    PH_ATTR
  } phase_t;

  phase_t                phase_r, phase_nxt;
  xrcd_pkg::run_mode_t   mode_r, mode_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt, rem_dec;
  logic [7:0]            char_r, char_nxt;
  logic [7:0]            attr_r, attr_nxt;
  logic [PEND_W-1:0]     pend_r, pend_nxt;
  logic                  rst_flight_r, rst_flight_nxt;
  logic [REM_W-1:0]      push_cells;
  logic                  accept, drained, hazard;
  logic [SUM_W-1:0]      row_bound;
  logic [xrcd_pkg::COORD_W-1:0] row_base;
  logic [7:0]            b;

  // While cells are still owed, the row can grow by at most one per owed cell
  // plus one wrap, so a run byte waits only if that bound could reach the height.
  assign drained   = q_empty && !bk.busy;
  assign row_base  = rst_flight_r ? '0 : bk.row;
  assign row_bound = SUM_W'(row_base) + SUM_W'(pend_r) + SUM_W'(1);
  assign hazard    = !drained && (row_bound >= SUM_W'(image_height));
  assign in_full   = q_full || ((phase_r == PH_RUN) && hazard);
  assign accept    = in_push && !in_full;
  assign b         = in_item.data_byte;
  assign rem_dec   = rem_r - 1'b1;

  always_comb begin
    phase_nxt  = phase_r;
    mode_nxt   = mode_r;
    rem_nxt    = rem_r;
    char_nxt   = char_r;
    attr_nxt   = attr_r;
    q_push     = 1'b0;
    q_data     = '0;
    push_cells = '0;
    if (accept) begin
      if (in_item.frame_start || (phase_r == PH_RUN)) begin
        if (in_item.frame_start) begin
          q_push         = 1'b1;
          q_data.restart = 1'b1;
        end
        if (in_item.frame_start || !(drained && (bk.row >= image_height))) begin
          mode_nxt  = xrcd_pkg::run_mode_t'(b[7:6]);
          rem_nxt   = REM_W'(b[5:0]) + 1'b1;
          char_nxt  = '0;
          attr_nxt  = '0;
          phase_nxt = (xrcd_pkg::run_mode_t'(b[7:6]) == xrcd_pkg::MODE_REP_ATTR) ?
                      PH_ATTR : PH_CHAR;
        end
      end else if (phase_r == PH_CHAR) begin
        char_nxt = b;
        if (mode_r == xrcd_pkg::MODE_REP_ATTR) begin
          q_push           = 1'b1;
          q_data.cell_char = b;
          q_data.attr      = attr_r;
          push_cells       = REM_W'(1);
          rem_nxt          = rem_dec;
          phase_nxt        = (rem_dec == '0) ? PH_RUN : PH_CHAR;
        end else begin
          phase_nxt = PH_ATTR;
        end
      end else begin
        attr_nxt = b;
        unique case (mode_r)
          xrcd_pkg::MODE_REP_ATTR: begin
            phase_nxt = PH_CHAR;
          end
          xrcd_pkg::MODE_REP_BOTH: begin
            q_push           = 1'b1;
            q_data.cell_char = char_r;
            q_data.attr      = b;
            q_data.len_m1    = rem_dec[xrcd_pkg::RUN_LEN_W-1:0];
            push_cells       = rem_r;
            rem_nxt          = '0;
            phase_nxt        = PH_RUN;
          end
          default: begin
            q_push           = 1'b1;
            q_data.cell_char = char_r;
            q_data.attr      = b;
            push_cells       = REM_W'(1);
            rem_nxt          = rem_dec;
            if (rem_dec == '0) begin
              phase_nxt = PH_RUN;
            end else begin
              phase_nxt = (mode_r == xrcd_pkg::MODE_REP_CHAR) ? PH_ATTR : PH_CHAR;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r + PEND_W'(push_cells) - PEND_W'(bk.cell_fire);
    if (q_push && q_data.restart) begin
      rst_flight_nxt = 1'b1;
    end else if (bk.restart_pop) begin
      rst_flight_nxt = 1'b0;
    end else begin
      rst_flight_nxt = rst_flight_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_RUN;
      mode_r       <= xrcd_pkg::MODE_NONE;
      rem_r        <= '0;
      char_r       <= '0;
      attr_r       <= '0;
      pend_r       <= '0;
      rst_flight_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      mode_r       <= mode_nxt;
      rem_r        <= rem_nxt;
      char_r       <= char_nxt;
      attr_r       <= attr_nxt;
      pend_r       <= pend_nxt;
      rst_flight_r <= rst_flight_nxt;
    end
  end

endmodule

// File: hdl/xrcd_back.sv
`timescale 1ns / 1ps
module xrcd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [xrcd_pkg::COORD_W-1:0]  image_width,
  input  logic [xrcd_pkg::COORD_W-1:0]  image_height,
  input  xrcd_pkg::job_t                q_data,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          o_push,
  output xrcd_pkg::out_item_t           o_data,
  input  logic                          o_full,
  output xrcd_pkg::back_status_t        bk
);

  logic                              busy_r, busy_nxt;
  logic [7:0]                        char_r, attr_r;
  logic [xrcd_pkg::RUN_LEN_W-1:0]    left_r, left_nxt;
  logic [xrcd_pkg::COORD_W-1:0]      col_r, col_nxt, row_r, row_nxt;
  logic [xrcd_pkg::COORD_W-1:0]      col0, row0, col1;
  logic                              fire, last, inb, load;
  logic [3:0]                        bg_raw;

  assign fire   = busy_r && !o_full;
  assign last   = (left_r == '0);
  assign q_pop  = !q_empty && (!busy_r || (fire && last));
  assign load   = q_pop && !q_data.restart;
  assign o_push = fire;
  assign bg_raw = attr_r[7:4];

  assign bk.busy        = busy_r;
  assign bk.cell_fire   = fire;
  assign bk.restart_pop = q_pop && q_data.restart;
  assign bk.row         = row_r;

  always_comb begin
    col0 = col_r;
    row0 = row_r;
    if ((row_r < image_height) && (col_r >= image_width)) begin
      col0 = '0;
      row0 = row_r + 1'b1;
    end
    inb  = (row0 < image_height) && (col0 < image_width);
    col1 = col0 + 1'b1;

    o_data.cell_char   = char_r;
    o_data.fg_index    = attr_r[3:0];
    o_data.bg_index    = (bg_raw > xrcd_pkg::BG_FOLD) ? bg_raw - xrcd_pkg::BG_FOLD : bg_raw;
    o_data.bold        = (char_r >= xrcd_pkg::BOLD_LOW) && (char_r <= xrcd_pkg::BOLD_HIGH);
    o_data.cell_col    = col0;
    o_data.cell_row    = row0;
    o_data.in_bounds   = inb;
    o_data.last_of_run = last;

    col_nxt  = col_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    busy_nxt = busy_r;
    if (fire) begin
      col_nxt  = col0;
      row_nxt  = row0;
      if (inb) begin
        if (col1 >= image_width) begin
          col_nxt = '0;
          row_nxt = row0 + 1'b1;
        end else begin
          col_nxt = col1;
        end
      end
      left_nxt = left_r - 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      if (q_data.restart) begin
        col_nxt = '0;
        row_nxt = '0;
      end else begin
        busy_nxt = 1'b1;
        left_nxt = q_data.len_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      left_r <= left_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= q_data.cell_char;
      attr_r <= q_data.attr;
    end
  end

endmodule

// File: hdl/xbin_rle_cell_decoder_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                          Beat moves when
// input     in         in_push, in_full, in_item      in_push && !in_full
// result    out        out_pop, out_empty, out_item   out_pop && !out_empty
// config    in         cfg_we, cfg_index, cfg_data    cfg_we
//
// One input byte is taken per cycle unless in_full is high; a byte that completes a cell is
// queued as a job, loaded into the back end and placed at one cell per cycle unless the
// result queue is full; a repeat-both run is one job of N cells while the front keeps taking bytes.
// A run byte waits while queued cells could still fill the image height.
// Reset is synchronous on rst_n and clears both queues, the parser and the position.
// A full result queue stalls the back end, then the job queue, then in_full.
module xbin_rle_cell_decoder_unit #(
  parameter int JOB_DEPTH = xrcd_pkg::JOB_DEPTH,
  parameter int OUT_DEPTH = xrcd_pkg::OUT_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  xrcd_pkg::in_item_t              in_item,
  output logic                            out_empty,
  input  logic                            out_pop,
  output xrcd_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [xrcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xrcd_pkg::COORD_W-1:0]    cfg_data
);

  localparam int JOB_W = $bits(xrcd_pkg::job_t);
  localparam int OUT_W = $bits(xrcd_pkg::out_item_t);

  logic [xrcd_pkg::COORD_W-1:0] width_r, width_nxt;
  logic [xrcd_pkg::COORD_W-1:0] height_r, height_nxt;

  logic                   jq_push, jq_full, jq_empty, jq_pop;
  xrcd_pkg::job_t         jq_wr, jq_rd;
  logic                   oq_push, oq_full;
  xrcd_pkg::out_item_t    oq_wr;
  xrcd_pkg::back_status_t bk;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we && (cfg_data != '0)) begin
      case (cfg_index)
        xrcd_pkg::REG_IMAGE_WIDTH:  width_nxt  = cfg_data;
        xrcd_pkg::REG_IMAGE_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= xrcd_pkg::WIDTH_RESET;
      height_r <= xrcd_pkg::HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  xrcd_front #(
    .JOB_DEPTH(JOB_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_item     (in_item),
    .image_height(height_r),
    .q_push      (jq_push),
    .q_data      (jq_wr),
    .q_full      (jq_full),
    .q_empty     (jq_empty),
    .bk          (bk)
  );

  xrcd_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(JOB_DEPTH)
  ) u_job_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (jq_push),
    .wr_data(jq_wr),
    .full   (jq_full),
    .pop    (jq_pop),
    .rd_data(jq_rd),
    .empty  (jq_empty)
  );

  xrcd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .image_width (width_r),
    .image_height(height_r),
    .q_data      (jq_rd),
    .q_empty     (jq_empty),
    .q_pop       (jq_pop),
    .o_push      (oq_push),
    .o_data      (oq_wr),
    .o_full      (oq_full),
    .bk          (bk)
  );

  xrcd_fifo #(
    .WIDTH(OUT_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (oq_push),
    .wr_data(oq_wr),
    .full   (oq_full),
    .pop    (out_pop),
    .rd_data(out_item),
    .empty  (out_empty)
  );

endmodule
